/* design/searchable_fifo_queue_assert.svh */
// Assertion macros for the searchable FIFO queue RTL, included by its top module.
// They expect the including module to have ports clk and arst_n.
`ifndef SEARCHABLE_FIFO_QUEUE_ASSERT_SVH
`define SEARCHABLE_FIFO_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SFQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfq: same-cycle check failed");
// next-cycle implication
`define SFQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfq: next-cycle check failed");
`else
`define SFQ_ASSERT_IMP(lbl, ante, cons)
`define SFQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* design/sfq_pkg.sv */
// Types and constants of the searchable FIFO queue.
// No dependencies; used by sfq_cell, sfq_ctrl and searchable_fifo_queue.
package sfq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int OCC_W = 5;

	// operation codes
	localparam logic [1:0] KIND_PUSH   = 2'd0;
	localparam logic [1:0] KIND_POP    = 2'd1;
	localparam logic [1:0] KIND_SEARCH = 2'd2;

	// result status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] value;
	} op_beat_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             found;
		logic [OCC_W-1:0] occupancy;
	} res_beat_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic               take;
		logic               push;
		logic               pop;
		logic               search;
		logic signed [31:0] value;
	} cell_cmd_t;

endpackage

/* design/searchable_fifo_queue.sv */
// Searchable FIFO queue: DEPTH signed 32-bit entries in a row of cells, slot 0 is
// the head. Each operation (push, pop, search) is one beat and gives one result
// beat. While the result side is not stalling, one operation is taken every cycle.
// Stage 1 registers status and count at the accepting edge, when the cells also
// update and register their match flags. When stage 1 advances, the OR over all
// DEPTH match flags loads the result register, which offers the result beat. A
// stalled result register holds the input as soon as the stage in front of it is also occupied.
// A push to a full queue is dropped with status full; pop or search on an empty
// queue reports empty. Depends on sfq_pkg, sfq_cell, sfq_ctrl.
`include "searchable_fifo_queue_assert.svh"

module searchable_fifo_queue import sfq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      op_valid,
	output logic      op_stall,
	input  op_beat_t  op,
	output logic      res_valid,
	input  logic      res_stall,
	output res_beat_t res
);

	cell_cmd_t          cmd;
	logic [CNT_W-1:0]   fill_count;
	logic [DEPTH-1:0]   valid_vec;
	logic [DEPTH-1:0]   match_vec;
	logic signed [31:0] value_arr [DEPTH];
	logic               take_push;
	logic               take_pop;

	sfq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_valid   (op_valid),
		.op_stall   (op_stall),
		.op         (op),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.match_vec  (match_vec),
		.cmd        (cmd),
		.fill_count (fill_count)
	);

	// row of cells; each takes from its upper neighbor on pop
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic               prev_v;
		logic               next_v;
		logic signed [31:0] next_d;

		if (i == 0) begin : g_head
			assign prev_v = 1'b1;
		end else begin : g_body
			assign prev_v = valid_vec[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_v = 1'b0;
			assign next_d = '0;
		end else begin : g_link
			assign next_v = valid_vec[i+1];
			assign next_d = value_arr[i+1];
		end

		sfq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_valid (prev_v),
			.next_valid (next_v),
			.next_value (next_d),
			.valid      (valid_vec[i]),
			.value      (value_arr[i]),
			.match      (match_vec[i])
		);
	end

	// accepted push that fits, accepted pop that has something to remove
	assign take_push = op_valid && !op_stall && op.kind == KIND_PUSH
		&& fill_count != CNT_W'(DEPTH);
	assign take_pop  = op_valid && !op_stall && op.kind == KIND_POP && fill_count != '0;

	// valid bits track the fill count and stay packed at the head
	`SFQ_ASSERT_IMP(a_valid_count, 1'b1, $countones(valid_vec) == fill_count)
	`SFQ_ASSERT_IMP(a_valid_packed, 1'b1, (valid_vec & (valid_vec + DEPTH'(1))) == '0)
	`SFQ_ASSERT_IMP(a_match_valid, 1'b1, (match_vec & ~valid_vec) == '0)
	`SFQ_ASSERT_NXT(a_push_grows, take_push, fill_count == $past(fill_count) + CNT_W'(1))
	`SFQ_ASSERT_NXT(a_pop_shrinks, take_pop, fill_count == $past(fill_count) - CNT_W'(1))

endmodule

/* design/sfq_cell.sv */
// One storage cell of the queue row: value, valid bit and search match flag.
// Depends on sfq_pkg.
module sfq_cell import sfq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_cmd_t          cmd,
	input  logic               prev_valid,
	input  logic               next_valid,
	input  logic signed [31:0] next_value,
	output logic               valid,
	output logic signed [31:0] value,
	output logic               match
);

	logic               valid_q;
	logic signed [31:0] value_q;
	logic               match_q;
	logic               push_here;

	// a push lands in the first empty cell
	assign push_here = cmd.push && !valid_q && prev_valid;

	// control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else if (cmd.take) begin
			if (cmd.pop) begin
				valid_q <= next_valid;
			end else if (push_here) begin
				valid_q <= 1'b1;
			end
			match_q <= cmd.search && valid_q && (value_q == cmd.value);
		end
	end

	// payload: shift down on pop, load on push
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			if (cmd.pop) begin
				value_q <= next_value;
			end else if (push_here) begin
				value_q <= cmd.value;
			end
		end
	end

	assign valid = valid_q;
	assign value = value_q;
	assign match = match_q;

endmodule

/* design/sfq_ctrl.sv */
// Queue control: handshakes, fill count, status and the result register.
// Depends on sfq_pkg.
module sfq_ctrl import sfq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             op_valid,
	output logic             op_stall,
	input  op_beat_t         op,
	output logic             res_valid,
	input  logic             res_stall,
	output res_beat_t        res,
	input  logic [DEPTH-1:0] match_vec,
	output cell_cmd_t        cmd,
	output logic [CNT_W-1:0] fill_count
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic [1:0]       status_nxt;
	logic             s1_valid_q;
	logic [1:0]       status_s1;
	logic [CNT_W-1:0] count_s1;
	logic             res_valid_q;
	res_beat_t        res_q;
	logic             advance;
	logic             take;
	logic             full;
	logic             empty;

	// handshake: stage 1 moves on when the result register is free
	assign advance  = s1_valid_q && (!res_valid_q || !res_stall);
	assign op_stall = s1_valid_q && !advance;
	assign take     = op_valid && !op_stall;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	// next count and status
	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_DONE;
		unique case (op.kind)
			KIND_PUSH: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			KIND_POP: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					count_nxt = count_q - CNT_W'(1);
				end
			end
			KIND_SEARCH: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end
			end
			default: begin
				status_nxt = ST_DONE;
			end
		endcase
	end

	// command to the cell row
	always_comb begin
		cmd.take   = take;
		cmd.push   = (op.kind == KIND_PUSH);
		cmd.pop    = (op.kind == KIND_POP);
		cmd.search = (op.kind == KIND_SEARCH);
		cmd.value  = op.value;
	end

	// fill count and stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q <= count_nxt;
			end
			if (take) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (take) begin
			status_s1 <= status_nxt;
			count_s1  <= count_nxt;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// result register payload; match flags are already gated by search
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.status    <= status_s1;
			res_q.found     <= |match_vec;
			res_q.occupancy <= OCC_W'(count_s1);
		end
	end

	assign res_valid  = res_valid_q;
	assign res        = res_q;
	assign fill_count = count_q;

endmodule

/* verif/searchable_fifo_queue_test.sv */
// Self-checking bench for searchable_fifo_queue: push, pop and search beats go in with
// random gaps and result stalls, and every result beat is checked against a queue model.
// Depends on sfq_pkg and the searchable_fifo_queue RTL.
module searchable_fifo_queue_test;
	import sfq_pkg::*;

	// kind code that the block ignores
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      op_valid = 1'b0;
	logic      op_stall;
	op_beat_t  op = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_beat_t res;

	searchable_fifo_queue uut (
		.clk(clk),
		.arst_n(arst_n),
		.op_valid(op_valid),
		.op_stall(op_stall),
		.op(op),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	// queue model and the result beats it still owes
	logic signed [31:0] model_entries[$];
	res_beat_t          pending_results[$];
	logic signed [31:0] recent_pushes[$];

	int error_count = 0;
	int n_push = 0, n_pop = 0, n_search = 0, n_unused = 0;
	int n_dropped = 0, n_empty = 0, n_hits = 0, peak_fill = 0;

	// idle controls shared by the test tasks and the two sides
	bit tx_idle_on = 1'b0;
	bit rx_idle_on = 1'b0;
	int hold_request = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("searchable_fifo_queue_test failed");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// search values favor recent pushes so hits are common
	function automatic logic signed [31:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2, 3, 4: return $urandom_range(0, 16) - 8;
			5, 6: begin
				if (recent_pushes.size() != 0)
					return recent_pushes[$urandom_range(0, recent_pushes.size() - 1)];
				return $urandom;
			end
			default: return $urandom;
		endcase
	endfunction

	// apply one operation to the model and return the result beat it gives
	function automatic res_beat_t predict_queue_op(op_beat_t beat);
		res_beat_t r;
		r = '0;
		r.status = ST_DONE;
		case (beat.kind)
			KIND_PUSH: begin
				n_push++;
				if (model_entries.size() >= DEPTH) begin
					r.status = ST_FULL;
					n_dropped++;
				end else
					model_entries.push_back(beat.value);
			end
			KIND_POP: begin
				n_pop++;
				if (model_entries.size() == 0) begin
					r.status = ST_EMPTY;
					n_empty++;
				end else
					void'(model_entries.pop_front());
			end
			KIND_SEARCH: begin
				n_search++;
				if (model_entries.size() == 0) begin
					r.status = ST_EMPTY;
					n_empty++;
				end else begin
					foreach (model_entries[i])
						if (model_entries[i] == beat.value)
							r.found = 1'b1;
					if (r.found)
						n_hits++;
				end
			end
			default: n_unused++;
		endcase
		if (model_entries.size() > peak_fill)
			peak_fill = model_entries.size();
		r.occupancy = OCC_W'(model_entries.size());
		return r;
	endfunction

	// predict on each accepted op beat, then check each accepted result beat
	always @(posedge clk) begin
		res_beat_t want;
		if (arst_n) begin
			if (op_valid && !op_stall)
				pending_results.push_back(predict_queue_op(op));
			if (res_valid && !res_stall) begin
				if (pending_results.size() == 0) begin
					$error("result beat with nothing expected: status %0d found %0d occ %0d",
						res.status, res.found, res.occupancy);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					if (res.status !== want.status) begin
						$error("status mismatch: expected %0d, got %0d", want.status, res.status);
						error_count++;
					end
					if (res.found !== want.found) begin
						$error("found mismatch: expected %0d, got %0d", want.found, res.found);
						error_count++;
					end
					if (res.occupancy !== want.occupancy) begin
						$error("occupancy mismatch: expected %0d, got %0d",
							want.occupancy, res.occupancy);
						error_count++;
					end
				end
			end
		end
	end

	// result side: random stalls, plus long hold-offs on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				res_stall <= 1'b1;
				repeat (hold_request) @(posedge clk);
				hold_request = 0;
				res_stall <= 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				res_stall <= 1'b1;
				repeat (gap_len() + 1) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// offer one op beat and hold it until taken, then maybe idle
	task automatic send_op(input logic [1:0] kind, input logic signed [31:0] value);
		int gap;
		op_valid <= 1'b1;
		op <= '{kind: kind, value: value};
		do
			@(posedge clk);
		while (op_stall);
		if (kind == KIND_PUSH) begin
			recent_pushes.push_back(value);
			if (recent_pushes.size() > 24)
				void'(recent_pushes.pop_front());
		end
		gap = tx_idle_on ? gap_len() : 0;
		if (gap > 0) begin
			op_valid <= 1'b0;
			op <= '{kind: 2'($urandom), value: $urandom};
			repeat (gap) @(posedge clk);
		end
	endtask

	// empty queue, value extremes, full queue, miss after pop, ignored kind
	task automatic test_directed();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send_op(KIND_SEARCH, 32'sd0);
		send_op(KIND_POP, 32'sd0);
		send_op(KIND_UNUSED, 32'sd5);
		send_op(KIND_PUSH, 32'sh8000_0000);
		send_op(KIND_PUSH, 32'sh7fff_ffff);
		send_op(KIND_PUSH, 32'sd0);
		send_op(KIND_PUSH, -32'sd1);
		send_op(KIND_PUSH, 32'sh5555_5555);
		send_op(KIND_PUSH, 32'shaaaa_aaaa);
		send_op(KIND_SEARCH, 32'sh8000_0000);
		send_op(KIND_SEARCH, 32'sh7fff_ffff);
		send_op(KIND_SEARCH, -32'sd1);
		// one bit away from a held value
		send_op(KIND_SEARCH, 32'sh7fff_fffe);
		for (int i = 0; i < 10; i++)
			send_op(KIND_PUSH, 100 + i);
		// queue is full now
		send_op(KIND_PUSH, 32'sh1234_5678);
		send_op(KIND_SEARCH, 32'sh1234_5678);
		send_op(KIND_UNUSED, 32'sd100);
		send_op(KIND_POP, 32'sd0);
		send_op(KIND_SEARCH, 32'sh8000_0000);
	endtask

	// phases of push-heavy, balanced and pop-heavy traffic with varied idling
	task automatic test_random_traffic(input int item_total);
		int sent;
		int push_pct;
		int r;
		logic [1:0] kind;
		sent = 0;
		while (sent < item_total) begin
			case ($urandom_range(0, 2))
				0: push_pct = 80;
				1: push_pct = 50;
				default: push_pct = 20;
			endcase
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(10, 60)) begin
				r = $urandom_range(0, 99);
				if (r == 0)
					kind = KIND_UNUSED;
				else if (r <= push_pct)
					kind = KIND_PUSH;
				else if ($urandom_range(0, 1))
					kind = KIND_POP;
				else
					kind = KIND_SEARCH;
				send_op(kind, pick_value());
				sent++;
			end
		end
	endtask

	// receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_backpressure();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		hold_request = 80;
		repeat (40) send_op($urandom_range(0, 3) == 0 ? KIND_SEARCH : KIND_PUSH, pick_value());
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		repeat (20) send_op(KIND_POP, $urandom);
	endtask

	initial begin
		int waited;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_random_traffic(1400);
		test_backpressure();

		// let the last beats drain
		op_valid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (pending_results.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_results.size() != 0) begin
			$error("%0d result beats never arrived", pending_results.size());
			error_count++;
		end
		repeat (6) @(posedge clk);

		$display("Ran %0d ops: %0d pushes (%0d dropped on full), %0d pops, %0d searches, %0d ignored",
			n_push + n_pop + n_search + n_unused, n_push, n_dropped, n_pop, n_search, n_unused);
		$display("Search hits %0d, empty-queue reports %0d, peak fill %0d of %0d",
			n_hits, n_empty, peak_fill, DEPTH);
		if (error_count == 0)
			$display("searchable_fifo_queue_test passed");
		else
			$display("searchable_fifo_queue_test failed");
		$finish;
	end

endmodule

/* searchable_fifo_queue.f */
+incdir+design
design/sfq_pkg.sv
design/sfq_cell.sv
design/sfq_ctrl.sv
design/searchable_fifo_queue.sv
verif/searchable_fifo_queue_test.sv
